@@ design/der_tlv_stream_parser_macros.svh @@
// Assertion helpers for the DER TLV stream parser.
// Both expect aclk and aresetn in scope.
`ifndef DER_TLV_STREAM_PARSER_MACROS_SVH
`define DER_TLV_STREAM_PARSER_MACROS_SVH

// Same-cycle implication.
`define DTLV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dtlv same-cycle check failed");

// Next-cycle implication.
`define DTLV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dtlv next-cycle check failed");

`endif

@@ design/dtlv_pkg.sv @@
package dtlv_pkg;

    localparam int MAX_DEPTH_DEF    = 8;
    localparam int OFFSET_WIDTH_DEF = 24;

    localparam int CFG_W    = 24;
    localparam int TDATA_W  = 72;
    localparam int TUSER_W  = 2;

    // DER header bits
    localparam int       LONG_FORM_BIT  = 7;
    localparam int       CONS_BIT       = 5;
    localparam int       MAX_LONG_COUNT = 4;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CONTENT = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_REGION = 2'd0;
    localparam logic [1:0] ERR_FORM   = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;
    localparam logic [1:0] ERR_DEPTH  = 2'd3;

    typedef struct packed {
        logic clear;      // restart: empty the stack
        logic step;       // a byte is consumed this cycle
        logic tag_phase;  // that byte is a tag byte: retire finished regions
        logic push;       // open a constructed region
    } stk_ctrl_t;

    typedef struct packed {
        logic               last;
        logic [TUSER_W-1:0] kind;
        logic [TDATA_W-1:0] data;
    } dtlv_beat_t;

endpackage

@@ design/dtlv_region_stack.sv @@
module dtlv_region_stack import dtlv_pkg::*; #(
    parameter int MAX_DEPTH    = MAX_DEPTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    localparam int CNT_W       = $clog2(MAX_DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  stk_ctrl_t               ctrl,
    input  logic [OFFSET_WIDTH-1:0] byte_offset,
    input  logic [OFFSET_WIDTH-1:0] buffer_len,
    input  logic [OFFSET_WIDTH-1:0] push_end,
    output logic [CNT_W-1:0]        depth,
    output logic [OFFSET_WIDTH-1:0] region_end
);

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [OFFSET_WIDTH-1:0] end_reg [MAX_DEPTH];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        kept;
    logic [IDX_W-1:0]        top_idx, wr_idx;

    // Region ends never grow toward the top, so the live entries are a prefix.
    always_comb begin
        kept = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if ((CNT_W'(i) < count_reg) && (end_reg[i] > byte_offset)) begin
                kept = CNT_W'(i + 1);
            end
        end
    end

    assign depth      = ctrl.tag_phase ? kept : count_reg;
    assign top_idx    = IDX_W'(depth - CNT_W'(1));
    assign wr_idx     = IDX_W'(depth);
    assign region_end = (depth == '0) ? buffer_len : end_reg[top_idx];

    always_comb begin
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.step) begin
            count_next = depth + CNT_W'(ctrl.push);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step && ctrl.push && !ctrl.clear) begin
            end_reg[wr_idx] <= push_end;
        end
    end

endmodule

@@ design/der_tlv_stream_parser.sv @@
// Each byte's result is registered onto m_*, or into the skid stage while m_* is stalled.
// Throughput: one byte per cycle; results leave through an output register plus skid stage,
// so s_tready drops only while both hold a beat.
// Reset (aresetn low, synchronous): parser at tag phase, offset 0, stack empty, no beats held,
// buffer_length 0. A cfg_we write also restarts the parse.
module der_tlv_stream_parser import dtlv_pkg::*; #(
    parameter int MAX_DEPTH    = MAX_DEPTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // config: buffer_length
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    // input bytes
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    // results
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] element_tag, [31:8] element_length,
                                          // [35:32] nest_depth, [59:36] content_offset,
                                          // [60] constructed, [68:61] content_byte,
                                          // [70:69] error_code, [71] zero
    output logic [TUSER_W-1:0] m_tuser,   // [1:0] kind
    output logic               m_tlast    // buffer_end
);

    localparam int OW    = OFFSET_WIDTH;
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    // wide enough for a 32-bit long-form length and any offset sum
    localparam int CW    = ((OW + 1) > 32) ? (OW + 1) : 32;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_LONG,
        PH_CONTENT
    } phase_t;

    // ---------------- parse state ----------------
    phase_t         phase_reg, phase_next;
    logic [CFG_W-1:0] blen_cfg_reg, blen_cfg_next;
    logic [OW-1:0]  offset_reg, offset_next;
    logic [7:0]     held_tag_reg, held_tag_next;
    logic [31:0]    acc_reg, acc_next;
    logic [2:0]     len_left_reg, len_left_next;
    logic [OW-1:0]  content_left_reg, content_left_next;
    logic           failed_reg, failed_next;

    // ---------------- output stage ----------------
    dtlv_beat_t     m_beat_reg, m_beat_next;
    dtlv_beat_t     skid_beat_reg, skid_beat_next;
    logic           m_valid_reg, m_valid_next;
    logic           skid_valid_reg, skid_valid_next;

    // ---------------- datapath ----------------
    logic [OW-1:0]  blen;
    logic [OW:0]    o_inc;
    logic           active, accept, step, is_last;
    logic [7:0]     b;
    logic [6:0]     long_cnt;
    logic [OW+1:0]  long_end;
    logic [31:0]    acc_shift;
    logic [31:0]    hdr_len;
    logic [OW:0]    room;
    logic           start_past, hdr_overrun, hdr_cons, depth_full;
    logic [OW-1:0]  hdr_end;
    logic [OW-1:0]  content_dec;

    logic [CNT_W-1:0] stk_depth;
    logic [OW-1:0]    rend;
    stk_ctrl_t        stk_ctrl;

    // result of this beat
    logic           res_push;
    logic [1:0]     res_kind, res_err;
    logic [31:0]    res_len;
    logic [OW-1:0]  res_off;
    logic           res_cons;
    logic [7:0]     res_byte;
    logic [7:0]     res_tag;
    dtlv_beat_t     res_beat;
    logic           hdr_req, push_en;

    assign blen     = OW'(blen_cfg_reg);
    assign b        = s_tdata;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    // bytes past the buffer end and everything after an error are swallowed
    assign active   = !failed_reg && (offset_reg < blen);
    assign step     = accept && active && !cfg_we;
    assign o_inc    = {1'b0, offset_reg} + (OW + 1)'(1);
    assign is_last  = (o_inc == {1'b0, blen});

    assign long_cnt  = b[6:0];
    assign long_end  = {1'b0, o_inc} + (OW + 2)'(long_cnt);
    assign acc_shift = {acc_reg[23:0], b};
    assign hdr_len   = (phase_reg == PH_LEN) ? {24'd0, b} : acc_shift;

    // content starts right after this byte; it must fit in what the region has left
    assign start_past  = o_inc > {1'b0, rend};
    assign room        = {1'b0, rend} - o_inc;
    assign hdr_overrun = start_past || (CW'(hdr_len) > CW'(room));
    assign hdr_end     = OW'(CW'(o_inc) + CW'(hdr_len));
    assign hdr_cons    = held_tag_reg[CONS_BIT];
    assign depth_full  = stk_depth >= CNT_W'(MAX_DEPTH);
    assign content_dec = (content_left_reg != '0) ? content_left_reg - OW'(1) : '0;

    assign stk_ctrl.clear     = cfg_we;
    assign stk_ctrl.step      = step;
    assign stk_ctrl.tag_phase = (phase_reg == PH_TAG);
    assign stk_ctrl.push      = push_en;

    dtlv_region_stack #(
        .MAX_DEPTH    (MAX_DEPTH),
        .OFFSET_WIDTH (OW)
    ) u_stack (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (stk_ctrl),
        .byte_offset (offset_reg),
        .buffer_len  (blen),
        .push_end    (hdr_end),
        .depth       (stk_depth),
        .region_end  (rend)
    );

    // ---------------- per-byte decode ----------------
    always_comb begin
        phase_next        = phase_reg;
        offset_next       = offset_reg;
        held_tag_next     = held_tag_reg;
        acc_next          = acc_reg;
        len_left_next     = len_left_reg;
        content_left_next = content_left_reg;
        failed_next       = failed_reg;
        blen_cfg_next     = blen_cfg_reg;

        res_push = 1'b0;
        res_kind = KIND_HEADER;
        res_err  = ERR_REGION;
        res_len  = '0;
        res_off  = offset_reg;
        res_cons = 1'b0;
        res_byte = '0;
        hdr_req  = 1'b0;
        push_en  = 1'b0;

        if (cfg_we) begin
            // new buffer: restart from scratch
            blen_cfg_next     = cfg_wdata;
            phase_next        = PH_TAG;
            offset_next       = '0;
            held_tag_next     = '0;
            acc_next          = '0;
            len_left_next     = '0;
            content_left_next = '0;
            failed_next       = 1'b0;
        end else if (step) begin
            offset_next = o_inc[OW-1:0];
            unique case (phase_reg)
                PH_TAG: begin
                    held_tag_next = b;
                    if (o_inc >= {1'b0, rend}) begin
                        // tag is the region's last byte: no room for a length
                        res_push = 1'b1;
                        res_kind = KIND_ERROR;
                        res_err  = ERR_REGION;
                    end else begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (!b[LONG_FORM_BIT]) begin
                        hdr_req = 1'b1;
                    end else if ((long_cnt == '0) || (long_cnt > 7'(MAX_LONG_COUNT))) begin
                        res_push = 1'b1;
                        res_kind = KIND_ERROR;
                        res_err  = ERR_FORM;
                    end else if (long_end > {2'b0, rend}) begin
                        res_push = 1'b1;
                        res_kind = KIND_ERROR;
                        res_err  = ERR_REGION;
                    end else begin
                        acc_next      = '0;
                        len_left_next = long_cnt[2:0];
                        phase_next    = PH_LONG;
                    end
                end
                PH_LONG: begin
                    acc_next      = acc_shift;
                    len_left_next = (len_left_reg != '0) ? len_left_reg - 3'd1 : 3'd0;
                    if (len_left_reg <= 3'd1) begin
                        hdr_req = 1'b1;
                    end
                end
                PH_CONTENT: begin
                    content_left_next = content_dec;
                    if (content_dec == '0) begin
                        phase_next = PH_TAG;
                    end
                    res_push = 1'b1;
                    res_kind = KIND_CONTENT;
                    res_byte = b;
                end
                default: begin
                    phase_next = PH_TAG;
                end
            endcase

            // length complete: check it against the region, then emit the header
            if (hdr_req) begin
                res_push = 1'b1;
                if (hdr_overrun) begin
                    res_kind = KIND_ERROR;
                    res_err  = ERR_LENGTH;
                end else begin
                    phase_next = PH_TAG;
                    if (hdr_cons && (hdr_len != '0) && depth_full) begin
                        res_kind = KIND_ERROR;
                        res_err  = ERR_DEPTH;
                    end else begin
                        res_kind = KIND_HEADER;
                        res_len  = hdr_len;
                        res_off  = o_inc[OW-1:0];
                        res_cons = hdr_cons;
                        if (hdr_cons) begin
                            push_en = (hdr_len != '0);
                        end else if (hdr_len != '0) begin
                            phase_next        = PH_CONTENT;
                            content_left_next = OW'(hdr_len);
                        end
                    end
                end
            end

            if (res_push && (res_kind == KIND_ERROR)) begin
                failed_next = 1'b1;
            end
        end
    end

    // tag byte that errors reports itself as the tag
    assign res_tag = (phase_reg == PH_TAG) ? b : held_tag_reg;

    always_comb begin
        res_beat.last = is_last;
        res_beat.kind = res_kind;
        res_beat.data = {1'b0, res_err, res_byte, res_cons, 24'(res_off),
                         4'(stk_depth), res_len[23:0], res_tag};
    end

    // ---------------- output register + skid ----------------
    always_comb begin
        m_beat_next     = m_beat_reg;
        skid_beat_next  = skid_beat_reg;
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (m_valid_reg && m_tready) begin
                m_beat_next     = skid_beat_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res_push) begin
            if (!m_valid_reg || m_tready) begin
                m_beat_next  = res_beat;
                m_valid_next = 1'b1;
            end else begin
                skid_beat_next  = res_beat;
                skid_valid_next = 1'b1;
            end
        end else if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_beat_reg    <= m_beat_next;
        skid_beat_reg <= skid_beat_next;
        if (!aresetn) begin
            phase_reg        <= PH_TAG;
            blen_cfg_reg     <= '0;
            offset_reg       <= '0;
            held_tag_reg     <= '0;
            acc_reg          <= '0;
            len_left_reg     <= '0;
            content_left_reg <= '0;
            failed_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            blen_cfg_reg     <= blen_cfg_next;
            offset_reg       <= offset_next;
            held_tag_reg     <= held_tag_next;
            acc_reg          <= acc_next;
            len_left_reg     <= len_left_next;
            content_left_reg <= content_left_next;
            failed_reg       <= failed_next;
            m_valid_reg      <= m_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_beat_reg.data;
    assign m_tuser  = m_beat_reg.kind;
    assign m_tlast  = m_beat_reg.last;

    // ---------------- checks ----------------
`include "der_tlv_stream_parser_macros.svh"

    `DTLV_ASSERT_SAME(a_skid_behind_main, skid_valid_reg, m_valid_reg)
    `DTLV_ASSERT_SAME(a_silent_after_fail, failed_reg, !res_push)
    `DTLV_ASSERT_NEXT(a_error_latches, res_push && (res_kind == KIND_ERROR) && !cfg_we, failed_reg)
    `DTLV_ASSERT_SAME(a_depth_bounded, 1'b1, stk_depth <= CNT_W'(MAX_DEPTH))

endmodule
